>>> design/route_table_longest_prefix_match_core_macros.svh
// Assertion macros shared by the routing table design files.
`ifndef ROUTE_TABLE_LONGEST_PREFIX_MATCH_CORE_MACROS_SVH
`define ROUTE_TABLE_LONGEST_PREFIX_MATCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while in reset.
`define RTLPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and ignored while in reset.
`define RTLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rtlpm_pkg.sv
// Shared types, codes and default sizes of the routing table.
`default_nettype none
package rtlpm_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int IFACE_BITS_DEF = 4;
	localparam int IP_W = 32;
	localparam int MATCH_IDX_W = 5;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ADD = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	typedef struct packed {
		logic [IP_W-1:0] dest;
		logic [IP_W-1:0] mask;
		logic [IP_W-1:0] gateway;
	} route_t;

	typedef struct packed {
		logic take;
		logic hit;
	} match_t;

endpackage
`default_nettype wire

>>> design/route_table_longest_prefix_match_core.sv
// Top level of the IPv4 longest-prefix-match routing table.
`default_nettype none
`include "route_table_longest_prefix_match_core_macros.svh"

// A word is taken when start is high and busy is low. Its one result word appears
// with done high for exactly one cycle and must be taken then, since the receiver
// cannot stall. Clear, add, the unused kind and a lookup on an empty table go
// straight to the result state after the accepting edge, where busy and done are
// high. A lookup on a non-empty table reads the stored routes one per cycle from
// the route RAM and feeds each through the single compare unit. Its busy period
// holds one read per route, the compare of the last route, the exit from the
// scan, and the result with done high. After reset the table is empty and needs
// no clearing pass.
module route_table_longest_prefix_match_core
	import rtlpm_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IFACE_BITS = IFACE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            kind,
	input  wire logic [IP_W-1:0]       address,
	input  wire logic [IP_W-1:0]       route_mask,
	input  wire logic [IP_W-1:0]       route_gateway,
	input  wire logic [IFACE_BITS-1:0] route_iface,
	output logic                       done,
	output logic                       found,
	output logic [IP_W-1:0]            next_gateway,
	output logic [IFACE_BITS-1:0]      out_iface,
	output logic [MATCH_IDX_W-1:0]     match_index,
	output logic                       table_full
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int RAM_W = $bits(route_t) + IFACE_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [IP_W-1:0]       addr_q;
	logic [IP_W-1:0]       best_mask_q;
	logic                  found_q;
	logic [IP_W-1:0]       gw_q;
	logic [IFACE_BITS-1:0] iface_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  full_q;

	logic                  accept;
	logic                  tbl_full;
	logic                  ram_we;
	logic                  ram_re;
	logic [RAM_W-1:0]      ram_wdata;
	logic [RAM_W-1:0]      ram_rdata;
	route_t                rd_route;
	logic [IFACE_BITS-1:0] rd_iface;
	match_t                cmp;
	logic [31:0]           idx_ext;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign tbl_full = (count_q == CNT_W'(ENTRIES));
	assign ram_we = accept && (kind == KIND_ADD) && !tbl_full;
	assign ram_re = (state_q == ST_SCAN) && (rd_q < count_q);
	assign ram_wdata = {address, route_mask, route_gateway, route_iface};
	assign rd_route = ram_rdata[RAM_W-1:IFACE_BITS];
	assign rd_iface = ram_rdata[IFACE_BITS-1:0];

	rtlpm_ram #(
		.WIDTH(RAM_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	rtlpm_match u_match (
		.address  (addr_q),
		.route    (rd_route),
		.best_mask(best_mask_q),
		.result   (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_q <= '0;
					vld_s1 <= 1'b0;
					if (accept) begin
						state_q <= ST_RESP;
						case (kind)
							KIND_CLEAR: count_q <= '0;
							KIND_ADD: begin
								if (!tbl_full) begin
									count_q <= count_q + 1'b1;
								end
							end
							KIND_LOOKUP: begin
								if (count_q != '0) begin
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					vld_s1 <= ram_re;
					if (ram_re) begin
						rd_q <= rd_q + 1'b1;
					end else if (!vld_s1) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result words and scan data need no reset; done qualifies them.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IDX_W-1:0];
		if (accept) begin
			addr_q <= address;
			best_mask_q <= '0;
			found_q <= 1'b0;
			gw_q <= '0;
			iface_q <= '0;
			idx_q <= '0;
			full_q <= (kind == KIND_ADD) && tbl_full;
		end else if ((state_q == ST_SCAN) && vld_s1 && cmp.take) begin
			best_mask_q <= rd_route.mask;
			found_q <= 1'b1;
			gw_q <= rd_route.gateway;
			iface_q <= rd_iface;
			idx_q <= idx_s1;
		end
	end

	assign idx_ext = 32'(idx_q);
	assign done = (state_q == ST_RESP);
	assign found = found_q;
	assign next_gateway = gw_q;
	assign out_iface = iface_q;
	assign match_index = idx_ext[MATCH_IDX_W-1:0];
	assign table_full = full_q;

	`RTLPM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(ENTRIES), "route count past depth")
	`RTLPM_ASSERT_NEXT(a_done_single, done, !done, "done strobe longer than one cycle")
	`RTLPM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`RTLPM_ASSERT_NOW(a_full_no_hit, done && table_full, !found, "full flag with a lookup hit")
	`RTLPM_ASSERT_NOW(a_scan_nonempty, state_q == ST_SCAN, count_q != '0, "scan of an empty table")

endmodule
`default_nettype wire

>>> design/rtlpm_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module rtlpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/rtlpm_match.sv
// Route compare unit: decides whether one stored route replaces the current best.
`default_nettype none
module rtlpm_match
	import rtlpm_pkg::*;
(
	input  wire logic [IP_W-1:0] address,
	input  wire route_t          route,
	input  wire logic [IP_W-1:0] best_mask,
	output match_t               result
);

	// A later route with an equal mask wins, hence the non-strict compare.
	always_comb begin
		result.hit = ((address & route.mask) == (route.dest & route.mask));
		result.take = result.hit && (best_mask <= route.mask);
	end

endmodule
`default_nettype wire

>>> dv/route_table_longest_prefix_match_core_test.sv
// Self-checking testbench for the longest-prefix-match routing table core.
module route_table_longest_prefix_match_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rtlpm_pkg::*;

	localparam int ENTRIES = ENTRIES_DEF;
	localparam int IFACE_BITS = IFACE_BITS_DEF;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 750;
	localparam int MAX_GAP = 12;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = ENTRIES + 8;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [1:0]            kind;
		logic [IP_W-1:0]       address;
		logic [IP_W-1:0]       mask;
		logic [IP_W-1:0]       gateway;
		logic [IFACE_BITS-1:0] iface;
		int unsigned           gap;
	} route_cmd_t;

	typedef struct packed {
		logic                   found;
		logic [IP_W-1:0]        gateway;
		logic [IFACE_BITS-1:0]  iface;
		logic [MATCH_IDX_W-1:0] slot;
		logic                   full;
	} route_answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [1:0]             kind;
	logic [IP_W-1:0]        address;
	logic [IP_W-1:0]        route_mask;
	logic [IP_W-1:0]        route_gateway;
	logic [IFACE_BITS-1:0]  route_iface;
	logic                   done;
	logic                   found;
	logic [IP_W-1:0]        next_gateway;
	logic [IFACE_BITS-1:0]  out_iface;
	logic [MATCH_IDX_W-1:0] match_index;
	logic                   table_full;

	route_cmd_t    route_cmds[$];
	route_answer_t answers_due[$];

	// Routes as the predictor sees them.
	logic [IP_W-1:0]       held_dest[ENTRIES];
	logic [IP_W-1:0]       held_mask[ENTRIES];
	logic [IP_W-1:0]       held_gateway[ENTRIES];
	logic [IFACE_BITS-1:0] held_iface[ENTRIES];
	int                    held_count = 0;

	// Routes added since the last clear, used to aim lookups at real prefixes.
	logic [IP_W-1:0] gen_dest[$];
	logic [IP_W-1:0] gen_mask[$];
	bit              run_fast = 1'b0;

	int  words_total = 0;
	int  words_built = 0;
	int  words_taken = 0;
	int  results_seen = 0;
	int  mismatch_count = 0;
	int  idle_cycles = 0;
	int  gap_waited = 0;
	logic took = 1'b0;

	route_table_longest_prefix_match_core #(
		.ENTRIES(ENTRIES),
		.IFACE_BITS(IFACE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.address(address),
		.route_mask(route_mask),
		.route_gateway(route_gateway),
		.route_iface(route_iface),
		.done(done),
		.found(found),
		.next_gateway(next_gateway),
		.out_iface(out_iface),
		.match_index(match_index),
		.table_full(table_full)
	);

	always #2 clk = ~clk;

	function automatic route_answer_t route_table_answer(input logic [1:0] k,
			input logic [IP_W-1:0] addr, input logic [IP_W-1:0] mask,
			input logic [IP_W-1:0] gw, input logic [IFACE_BITS-1:0] ifc);
		route_answer_t ans;
		logic hit;
		logic [IP_W-1:0] best_mask;
		int best;
		ans = '0;
		hit = 1'b0;
		best_mask = '0;
		best = 0;
		case (k)
			KIND_CLEAR: begin
				held_count = 0;
			end
			KIND_ADD: begin
				if (held_count >= ENTRIES) begin
					ans.full = 1'b1;
				end else begin
					held_dest[held_count] = addr;
					held_mask[held_count] = mask;
					held_gateway[held_count] = gw;
					held_iface[held_count] = ifc;
					held_count++;
				end
			end
			KIND_LOOKUP: begin
				// The greatest mask wins; a later route takes a tie.
				for (int i = 0; i < held_count; i++) begin
					if (((addr ^ held_dest[i]) & held_mask[i]) == '0 &&
							best_mask <= held_mask[i]) begin
						hit = 1'b1;
						best_mask = held_mask[i];
						best = i;
					end
				end
				if (hit) begin
					ans.found = 1'b1;
					ans.gateway = held_gateway[best];
					ans.iface = held_iface[best];
					ans.slot = best[MATCH_IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	function automatic logic [IP_W-1:0] prefix_mask(input int len);
		return (len == 0) ? '0 : (~32'h0 << (IP_W - len));
	endfunction

	// The interface index comes in as a full random word and keeps its low bits.
	function automatic void queue_cmd(input logic [1:0] k, input logic [IP_W-1:0] addr,
			input logic [IP_W-1:0] mask, input logic [IP_W-1:0] gw,
			input int unsigned ifc);
		route_cmd_t c;
		c.kind = k;
		c.address = addr;
		c.mask = mask;
		c.gateway = gw;
		c.iface = IFACE_BITS'(ifc);
		c.gap = run_fast ? 0 : $urandom_range(0, MAX_GAP);
		route_cmds.push_back(c);
		words_total++;
		if (k == KIND_ADD) begin
			gen_dest.push_back(addr);
			gen_mask.push_back(mask);
		end else if (k == KIND_CLEAR) begin
			gen_dest.delete();
			gen_mask.delete();
		end
		if (k != KIND_UNUSED)
			words_built++;
	endfunction

	function automatic logic [IP_W-1:0] pick_lookup_address();
		int j;
		logic [IP_W-1:0] a;
		if (gen_dest.size() == 0 || $urandom_range(0, 7) == 0)
			return $urandom;
		j = $urandom_range(0, gen_dest.size() - 1);
		a = (gen_dest[j] & gen_mask[j]) | ($urandom & ~gen_mask[j]);
		// Now and then flip one bit so the chosen route just misses.
		if ($urandom_range(0, 7) == 0)
			a ^= 32'h1 << $urandom_range(0, IP_W - 1);
		return a;
	endfunction

	// Driver: a word stays on the inputs until the edge that takes it.
	always @(negedge clk) begin
		route_cmd_t c;
		logic present;
		if (arst_n) begin
			present = start && !took;
			if (!present && route_cmds.size() > 0) begin
				if (gap_waited < route_cmds[0].gap) begin
					gap_waited++;
				end else begin
					c = route_cmds.pop_front();
					kind <= c.kind;
					address <= c.address;
					route_mask <= c.mask;
					route_gateway <= c.gateway;
					route_iface <= c.iface;
					present = 1'b1;
					gap_waited = 0;
				end
			end
			start <= present;
		end
	end

	// Monitor: checks each result word, then predicts the word taken at this edge.
	always @(posedge clk) begin
		route_answer_t want;
		route_answer_t got;
		if (arst_n) begin
			if (done) begin
				got = {found, next_gateway, out_iface, match_index, table_full};
				results_seen++;
				if (answers_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("result %0d arrived with no word outstanding", results_seen);
				end else begin
					want = answers_due.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("result %0d: expected found=%0b gw=%h if=%0d idx=%0d full=%0b",
								results_seen, want.found, want.gateway, want.iface,
								want.slot, want.full);
							$display("result %0d: got      found=%0b gw=%h if=%0d idx=%0d full=%0b",
								results_seen, got.found, got.gateway, got.iface,
								got.slot, got.full);
						end
					end
				end
			end
			if (start && !busy) begin
				answers_due.push_back(route_table_answer(kind, address, route_mask,
					route_gateway, route_iface));
				words_taken++;
			end
			took <= start && !busy;
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int n_add;
		int n_look;
		int j;
		int directed_words;
		logic [IP_W-1:0] a;
		logic [IP_W-1:0] m;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_CLEAR;
		address = '0;
		route_mask = '0;
		route_gateway = '0;
		route_iface = '0;

		// Directed part: empty table, unused kind, default route, ties,
		// host route, a non-contiguous mask, and the extremes of each field.
		queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		queue_cmd(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		queue_cmd(KIND_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, '0);
		queue_cmd(KIND_ADD, 32'h0A00_0000, prefix_mask(8), 32'hFFFF_FFFF, '1);
		queue_cmd(KIND_ADD, 32'hC0A8_0101, prefix_mask(32), 32'h0000_0000, 4'd1);
		queue_cmd(KIND_ADD, 32'h0A00_0000, prefix_mask(8), 32'h1234_5678, 4'd7);
		queue_cmd(KIND_ADD, 32'hFFFF_FFFF, prefix_mask(1), 32'hDEAD_BEEF, 4'd2);
		queue_cmd(KIND_ADD, 32'h0055_0055, 32'h00FF_00FF, 32'h0000_0005, 4'd3);
		queue_cmd(KIND_LOOKUP, 32'h0A01_0203, '0, '0, '0);
		queue_cmd(KIND_LOOKUP, 32'hC0A8_0101, '0, '0, '0);
		queue_cmd(KIND_LOOKUP, 32'hC0A8_0102, '0, '0, '0);
		queue_cmd(KIND_LOOKUP, 32'h0808_0808, '0, '0, '0);
		queue_cmd(KIND_LOOKUP, 32'h0000_0000, '0, '0, '0);
		queue_cmd(KIND_LOOKUP, 32'h1255_0055, '0, '0, '0);
		queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		queue_cmd(KIND_UNUSED, 32'h0A00_00FF, '0, '0, '0);
		queue_cmd(KIND_LOOKUP, 32'h0A00_00FF, '0, '0, '0);
		queue_cmd(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		queue_cmd(KIND_LOOKUP, 32'h0A01_0203, '0, '0, '0);
		queue_cmd(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
		queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFE, '0, '0, '0);
		directed_words = words_built;

		// Random part: mostly clear, a run of adds, then lookups aimed at the
		// stored prefixes; some runs overfill the table.
		while (words_built < directed_words + RANDOM_WORDS) begin
			run_fast = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) != 0)
				queue_cmd(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
			if ($urandom_range(0, 7) == 0)
				queue_cmd(KIND_LOOKUP, $urandom, $urandom, $urandom, $urandom);
			n_add = ($urandom_range(0, 3) == 0) ? $urandom_range(ENTRIES, ENTRIES + 4)
				: $urandom_range(1, 10);
			for (int i = 0; i < n_add; i++) begin
				if (gen_dest.size() > 0 && $urandom_range(0, 4) == 0) begin
					// Same prefix again, so the later route must win the tie.
					j = $urandom_range(0, gen_dest.size() - 1);
					a = gen_dest[j];
					m = gen_mask[j];
				end else begin
					a = $urandom;
					m = ($urandom_range(0, 5) == 0) ? $urandom
						: prefix_mask($urandom_range(0, IP_W));
				end
				queue_cmd(KIND_ADD, a, m, $urandom, $urandom);
				if ($urandom_range(0, 3) == 0)
					queue_cmd(KIND_LOOKUP, pick_lookup_address(), $urandom, $urandom,
						$urandom);
			end
			n_look = $urandom_range(2, 10);
			for (int i = 0; i < n_look; i++)
				queue_cmd(KIND_LOOKUP, pick_lookup_address(), $urandom, $urandom, $urandom);
			if ($urandom_range(0, 9) == 0)
				queue_cmd(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_taken != words_total || answers_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/rtlpm_pkg.sv
design/rtlpm_ram.sv
design/rtlpm_match.sv
design/route_table_longest_prefix_match_core.sv
dv/route_table_longest_prefix_match_core_test.sv
